### design/rpnalu_pkg.sv
// ----------------------------------------------------------------------------
// rpnalu_pkg
// Shared constants, codes and types for the postfix stack evaluator.
// ----------------------------------------------------------------------------
package rpnalu_pkg;

  // default sizes
  localparam int DATA_WIDTH_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 16;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int OPERAND_W = 16;
  localparam int STATUS_W  = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_PUSH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SUB  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_MUL  = 2'd3;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming transaction, start the stack read
    logic commit;   // evaluate, update the stack and load the result register
  } dp_cmd_t;

endpackage

### design/rpnalu_ram.sv
// ----------------------------------------------------------------------------
// rpnalu_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module rpnalu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

### design/rpnalu_ctrl.sv
// ----------------------------------------------------------------------------
// rpnalu_ctrl
// Controller: two-state sequencer and output valid register.
// ----------------------------------------------------------------------------
module rpnalu_ctrl
  import rpnalu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_free;

  // output register can take a new result
  assign out_free = !out_valid || !out_stall;

  // commands to the datapath
  always_comb begin
    cmd.capture = (state == S_IDLE) && in_valid;
    cmd.commit  = (state == S_EXEC) && out_free;
  end

  assign in_stall = (state != S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### design/rpnalu_dpath.sv
// ----------------------------------------------------------------------------
// rpnalu_dpath
// Datapath: top-of-stack register, stack RAM for the entries below it,
// add/subtract/multiply unit with overflow checks, result registers.
// ----------------------------------------------------------------------------
module rpnalu_dpath
  import rpnalu_pkg::*;
#(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  dp_cmd_t                              cmd,
  input  logic [CMD_W-1:0]                     in_cmd,
  input  logic signed [OPERAND_W-1:0]          in_operand,
  output logic [STATUS_W-1:0]                  status,
  output logic signed [DATA_WIDTH-1:0]         top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]     stack_count
);

  localparam int DW = DATA_WIDTH;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int XW = 34;

  localparam logic signed [XW-1:0] VAL_MIN = -(34'sd1 <<< (DW - 1));
  localparam logic signed [XW-1:0] VAL_MAX = (34'sd1 <<< (DW - 1)) - 34'sd1;
  localparam logic signed [DW-1:0] MIN_W   = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] ONE_W   = {{(DW-1){1'b0}}, 1'b1};
  localparam logic [CW-1:0]        DEPTH_C = CW'(STACK_DEPTH);

  // latched transaction and stack state
  logic [CMD_W-1:0]            cmd_q;
  logic signed [OPERAND_W-1:0] opnd_q;
  logic [CW-1:0]               sp;
  logic [CW-1:0]               sp_next;
  logic signed [DW-1:0]        top_reg;
  logic signed [DW-1:0]        top_next;

  // ram port
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_addr;
  logic [DW-1:0] ram_rdata;

  // evaluation
  logic signed [XW-1:0]   ext_op;
  logic                   in_range;
  logic signed [DW-1:0]   a;
  logic signed [DW-1:0]   b;
  logic signed [DW:0]     sum;
  logic signed [DW:0]     diff;
  logic signed [2*DW-1:0] prod;
  logic signed [DW-1:0]   res;
  logic                   res_ok;
  logic [STATUS_W-1:0]    st;
  logic signed [DW-1:0]   other;
  logic [CW-1:0]          sp_m1;
  logic [CW-1:0]          sp_m2;

  assign sp_m1 = sp - CW'(1);
  assign sp_m2 = sp - CW'(2);

  // capture the transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= in_cmd;
      opnd_q <= in_operand;
    end
  end

  // stack ram: read second entry on capture, spill top on push
  assign ram_re   = cmd.capture && (in_cmd != CMD_PUSH) && (sp >= CW'(2));
  assign ram_we   = cmd.commit && (cmd_q == CMD_PUSH) && (st == ST_OK) && (sp != '0);
  assign ram_addr = ram_re ? sp_m2[AW-1:0] : sp_m1[AW-1:0];

  rpnalu_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (top_reg),
    .rdata (ram_rdata)
  );

  // operand range check
  assign ext_op   = XW'(opnd_q);
  assign in_range = (ext_op >= VAL_MIN) && (ext_op <= VAL_MAX);

  // arithmetic on second (a) and top (b)
  assign a     = $signed(ram_rdata);
  assign b     = top_reg;
  assign sum   = {a[DW-1], a} + {b[DW-1], b};
  assign diff  = {a[DW-1], a} - {b[DW-1], b};
  assign prod  = a * b;
  assign other = (a == MIN_W) ? b : a;

  always_comb begin
    res    = '0;
    res_ok = 1'b0;
    case (cmd_q)
      CMD_ADD: begin
        res    = sum[DW-1:0];
        res_ok = (sum[DW] == sum[DW-1]);
      end
      CMD_SUB: begin
        res    = diff[DW-1:0];
        res_ok = (b != MIN_W) && (diff[DW] == diff[DW-1]);
      end
      CMD_MUL: begin
        // a product with the minimum value is valid only times zero or one
        if ((a == MIN_W) || (b == MIN_W)) begin
          res    = (other == ONE_W) ? MIN_W : '0;
          res_ok = (other == '0) || (other == ONE_W);
        end else begin
          res    = prod[DW-1:0];
          res_ok = (prod[2*DW-1:DW-1] == {(DW+1){prod[DW-1]}})
                   && (prod[DW-1:0] != MIN_W);
        end
      end
      default: begin
        res    = '0;
        res_ok = 1'b0;
      end
    endcase
  end

  // status and next stack state
  always_comb begin
    st       = ST_OK;
    sp_next  = sp;
    top_next = top_reg;
    if (cmd_q == CMD_PUSH) begin
      if (!in_range) begin
        st = ST_RANGE;
      end else if (sp >= DEPTH_C) begin
        st = ST_FULL;
      end else begin
        sp_next  = sp + CW'(1);
        top_next = ext_op[DW-1:0];
      end
    end else if (sp < CW'(2)) begin
      st = ST_UNDERFLOW;
    end else if (!res_ok) begin
      st = ST_OVERFLOW;
    end else begin
      sp_next  = sp_m1;
      top_next = res;
    end
    if (st != ST_OK) begin
      sp_next = '0;
    end
  end

  // stack pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= '0;
    end else if (cmd.commit) begin
      sp <= sp_next;
    end
  end

  // top of stack and result registers
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      top_reg     <= top_next;
      status      <= st;
      top_value   <= (st == ST_OK) ? top_next : '0;
      stack_count <= sp_next;
    end
  end

endmodule

### design/rpn_stack_alu_int8_overflow_top.sv
// ----------------------------------------------------------------------------
// rpn_stack_alu_int8_overflow_top
// Postfix stack evaluator over signed values: push, add, subtract, multiply,
// with range, underflow, full and overflow reporting.
//
//   channel | handshake           | payload
//   --------+---------------------+----------------------------------------
//   in      | in_valid / in_stall | cmd, operand_value
//   out     | out_valid/out_stall | status, top_value, stack_count
//
// A transaction is accepted in the idle state, which reads the entry under
// the top from the stack ram (registered read), and evaluated in exec state.
// A result waiting in the output register holds the next evaluation only.
// Synchronous reset empties the stack; ram contents need no clearing.
// out_stall delays the commit of the transaction under evaluation.
// ----------------------------------------------------------------------------
module rpn_stack_alu_int8_overflow_top
  import rpnalu_pkg::*;
#(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [CMD_W-1:0]                 cmd,
  input  logic signed [OPERAND_W-1:0]      operand_value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [STATUS_W-1:0]              status,
  output logic signed [DATA_WIDTH-1:0]     top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0] stack_count
);

  dp_cmd_t dp_cmd;

  // sequencer
  rpnalu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (dp_cmd)
  );

  // stack and arithmetic
  rpnalu_dpath #(
    .DATA_WIDTH  (DATA_WIDTH),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (dp_cmd),
    .in_cmd      (cmd),
    .in_operand  (operand_value),
    .status      (status),
    .top_value   (top_value),
    .stack_count (stack_count)
  );

endmodule

### design/rpnalu_checker.sv
// ----------------------------------------------------------------------------
// rpnalu_checker
// Port-level checks on the stack evaluator, bound to the top level.
// ----------------------------------------------------------------------------
module rpnalu_checker
  import rpnalu_pkg::*;
#(
  parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [STATUS_W-1:0]              status,
  input logic signed [DATA_WIDTH-1:0]     top_value,
  input logic [$clog2(STACK_DEPTH+1)-1:0] stack_count
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status)
      && $stable(top_value) && $stable(stack_count))
    else $error("result changed while stalled");

  // any error leaves an empty stack
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> (stack_count == '0) && (top_value == '0))
    else $error("error without emptied stack");

  // a good transaction leaves at least one value
  a_ok_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_OK) |-> (stack_count != '0))
    else $error("ok status with empty stack");

  // count never exceeds the depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (stack_count <= CW'(STACK_DEPTH)))
    else $error("stack count beyond depth");

  // block is busy the cycle after it takes a transaction
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken back to back");

endmodule

bind rpn_stack_alu_int8_overflow_top rpnalu_checker #(
  .DATA_WIDTH  (DATA_WIDTH),
  .STACK_DEPTH (STACK_DEPTH)
) u_rpnalu_checker (.*);
